/* sv/tds_pkg.sv */
package tds_pkg;

	// Fixed input clock and count range
	localparam int unsigned INPUT_CLOCK_HZ = 2457600;
	localparam int unsigned MAX_COUNT      = 255;
	localparam int unsigned PRESC_N        = 7;

	// Payload widths
	localparam int unsigned TARGET_W = 16;
	localparam int unsigned FREQ_W   = 16;
	localparam int unsigned SEL_W    = 3;
	localparam int unsigned CNT_W    = 8;

	// Prescaled clock width; the smallest prescaler (4) gives the largest base
	localparam int unsigned BASE_W = $clog2(INPUT_CLOCK_HZ / 4 + 1);
	// Error width, one bit of headroom so the all-ones start value beats nothing
	localparam int unsigned ERR_W  = ((BASE_W > TARGET_W) ? BASE_W : TARGET_W) + 1;
	// Divider step counter
	localparam int unsigned STEP_W = $clog2(BASE_W + 1);

	// Prescaled clock per select code minus one (codes 1..7 = /4,/10,/16,/50,/64,/100,/200)
	localparam logic [BASE_W-1:0] BASE_TAB [PRESC_N] = '{
		BASE_W'(INPUT_CLOCK_HZ / 4),
		BASE_W'(INPUT_CLOCK_HZ / 10),
		BASE_W'(INPUT_CLOCK_HZ / 16),
		BASE_W'(INPUT_CLOCK_HZ / 50),
		BASE_W'(INPUT_CLOCK_HZ / 64),
		BASE_W'(INPUT_CLOCK_HZ / 100),
		BASE_W'(INPUT_CLOCK_HZ / 200)
	};

	localparam logic [SEL_W-1:0] SEL_FIRST = SEL_W'(PRESC_N);
	localparam logic [SEL_W-1:0] SEL_LAST  = SEL_W'(1);
	localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(MAX_COUNT);

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_DIV,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic              start;
		logic [BASE_W-1:0] dividend;
		logic [CNT_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [BASE_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* sv/tds_req_if.sv */
interface tds_req_if;
	import tds_pkg::*;

	logic                valid;
	logic                ready;
	logic [TARGET_W-1:0] target_hz;

	modport source (output valid, output target_hz, input ready);
	modport sink   (input valid, input target_hz, output ready);
endinterface

/* sv/tds_res_if.sv */
interface tds_res_if;
	import tds_pkg::*;

	logic              valid;
	logic              ready;
	logic [FREQ_W-1:0] achieved_hz;
	logic [SEL_W-1:0]  prescale_select;
	logic [CNT_W-1:0]  count_value;

	modport source (output valid, output achieved_hz, output prescale_select,
		output count_value, input ready);
	modport sink   (input valid, input achieved_hz, input prescale_select,
		input count_value, output ready);
endinterface

/* sv/tds_divider.sv */
module tds_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  tds_pkg::div_req_t req,
	output tds_pkg::div_rsp_t rsp
);
	import tds_pkg::*;

	// Restoring divider, one quotient bit per cycle
	logic [BASE_W-1:0] quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W:0] trial;
	logic           fits;
	logic [CNT_W:0] trial_sub;

	always_comb begin
		trial     = {rem_q, quo_q[BASE_W-1]};
		fits      = (trial >= {1'b0, dvs_q});
		trial_sub = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(BASE_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[BASE_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* sv/tds_seq.sv */
module tds_seq (
	input  logic              clk,
	input  logic              arst_n,
	tds_req_if.sink           request,
	tds_res_if.source         result,
	output tds_pkg::div_req_t div_req,
	input  tds_pkg::div_rsp_t div_rsp
);
	import tds_pkg::*;

	seq_state_t state_q, state_d;

	logic [TARGET_W-1:0] target_q;
	logic [SEL_W-1:0]    sel_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [ERR_W-1:0]    best_err_q;
	logic [BASE_W-1:0]   best_f_q;
	logic [SEL_W-1:0]    best_sel_q;
	logic [CNT_W-1:0]    best_cnt_q;

	logic              res_valid_q;
	logic [FREQ_W-1:0] res_f_q;
	logic [SEL_W-1:0]  res_sel_q;
	logic [CNT_W-1:0]  res_cnt_q;

	logic [SEL_W-1:0] sel_idx;
	logic [ERR_W-1:0] f_ext;
	logic [ERR_W-1:0] t_ext;
	logic [ERR_W-1:0] err;
	logic             below;
	logic             better;
	logic             stop;
	logic             last_cand;
	logic             res_free;

	// Candidate evaluation on the divider's finishing cycle
	always_comb begin
		sel_idx   = sel_q - SEL_W'(1);
		f_ext     = ERR_W'(div_rsp.quotient);
		t_ext     = ERR_W'(target_q);
		below     = (f_ext < t_ext);
		err       = below ? (t_ext - f_ext) : (f_ext - t_ext);
		better    = (err < best_err_q);
		stop      = below || (cnt_q == CNT_LAST);
		last_cand = stop && (sel_q == SEL_LAST);
		res_free  = !res_valid_q || result.ready;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (request.valid) state_d = S_START;
			S_START: state_d = S_DIV;
			S_DIV: begin
				if (div_rsp.done) state_d = last_cand ? S_DONE : S_START;
			end
			S_DONE:  if (res_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		request.ready    = (state_q == S_IDLE);
		div_req.start    = (state_q == S_START);
		div_req.dividend = BASE_TAB[sel_idx];
		div_req.divisor  = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && request.valid) begin
			target_q   <= request.target_hz;
			sel_q      <= SEL_FIRST;
			cnt_q      <= CNT_FIRST;
			best_err_q <= '1;
		end else if (state_q == S_DIV && div_rsp.done) begin
			if (better) begin
				best_err_q <= err;
				best_f_q   <= div_rsp.quotient;
				best_sel_q <= sel_q;
				best_cnt_q <= cnt_q;
			end
			if (stop) begin
				sel_q <= sel_q - SEL_W'(1);
				cnt_q <= CNT_FIRST;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
		if (state_q == S_DONE && res_free) begin
			res_f_q   <= FREQ_W'(best_f_q);
			res_sel_q <= best_sel_q;
			res_cnt_q <= best_cnt_q;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.achieved_hz     = res_f_q;
	assign result.prescale_select = res_sel_q;
	assign result.count_value     = res_cnt_q;

endmodule

/* sv/timer_divider_search.sv */
// Channel  | Dir | Payload                                      | Handshake
// request  | in  | target_hz[15:0]                              | valid/ready
// result   | out | achieved_hz[15:0] prescale_select[2:0]       | valid/ready
//          |     | count_value[7:0]                             |
//
// One transaction at a time. Each candidate takes a start, BASE_W divider
// steps at one quotient bit each and an evaluation, BASE_W = 20 here; a
// search is 7 to 7 x 255 candidates, run on the single shared restoring
// divider. Reset clears the sequencer and the result valid flag only;
// there is no state held between transactions. The result sits in an
// output register, so a new request is taken while the previous result
// waits; a stalled result only holds the sequencer at its final step.
module timer_divider_search (
	input  logic clk,
	input  logic arst_n,
	tds_req_if.sink   request,
	tds_res_if.source result
);
	import tds_pkg::*;

	// Divider handshake between the sequencer and the shared divide unit
	div_req_t div_req;
	div_rsp_t div_rsp;

	// Sequencer: walks prescalers 200 down to 4 and counts 1 upwards, keeps
	// the best candidate on a strictly smaller error, cuts a prescaler's
	// count run short once a frequency drops below the target.
	tds_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.result  (result),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	// Shared divider: prescaled clock / count, truncated.
	tds_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

// Testbench for timer_divider_search: each request transaction carries a wanted
// frequency, each result transaction the best prescaler select, count and the
// frequency that setting gives. Results are predicted locally and checked in
// order of acceptance.
module tb;
	import tds_pkg::*;

	// Prescaler divisors indexed by select code; entry 0 is never used
	localparam logic [7:0][7:0] PRESCALE_DIV = {
		8'd200, 8'd100, 8'd64, 8'd50, 8'd16, 8'd10, 8'd4, 8'd0
	};
	// Best error starts above anything a candidate can reach
	localparam int unsigned SEARCH_ERR_START = 32'hFF_FFFF;
	// Receiver hold-off for the stall test; long enough to fill the output
	// register and block the sequencer with a second search
	localparam int unsigned HOLD_CYCLES = 6000;
	localparam int unsigned RANDOM_ITEMS = 72;
	localparam int unsigned DRAIN_CYCLES = 100;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [SEL_W-1:0]  sel;
		logic [CNT_W-1:0]  cnt;
	} timer_setting_t;

	logic clk = 1'b0;
	logic arst_n;

	tds_req_if request_ch ();
	tds_res_if result_ch ();

	timer_divider_search DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request_ch),
		.result  (result_ch)
	);

	always #5 clk = ~clk;

	// Settings in flight, oldest first
	timer_setting_t pending_settings[$];
	int unsigned    mismatches = 0;

	// Idle rates in percent of cycles
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;

	// Hold-off requests: the receiver serves one each time the counts differ
	int unsigned holds_asked = 0;

	// Closest-frequency search: prescalers from the largest down, counts
	// upwards, strictly smaller error wins, count loop stops once the
	// candidate falls below the target
	function automatic timer_setting_t best_setting(input logic [TARGET_W-1:0] target);
		timer_setting_t best;
		int unsigned    base;
		int unsigned    freq;
		int unsigned    err;
		int unsigned    best_err;
		int unsigned    cnt;
		int unsigned    sel;
		bit             below;
		best     = '{freq: '0, sel: SEL_LAST, cnt: CNT_FIRST};
		best_err = SEARCH_ERR_START;
		for (sel = SEL_FIRST; sel >= SEL_LAST; sel--) begin
			base  = INPUT_CLOCK_HZ / PRESCALE_DIV[sel];
			cnt   = 1;
			below = 1'b0;
			while (cnt <= MAX_COUNT && !below) begin
				freq = base / cnt;
				err  = (target > freq) ? (target - freq) : (freq - target);
				if (err < best_err) begin
					best_err = err;
					// achieved frequency is reported modulo 2^16
					best.freq = freq[FREQ_W-1:0];
					best.sel  = sel[SEL_W-1:0];
					best.cnt  = cnt[CNT_W-1:0];
				end
				below = (freq < target);
				cnt++;
			end
		end
		return best;
	endfunction

	// Offer one request transaction. Valid stays high straight into the next
	// item when no gap is drawn, so it is never lowered and raised in one step.
	task automatic send_target(input logic [TARGET_W-1:0] target);
		if ($urandom_range(99) < tx_idle_pct) begin
			request_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		request_ch.valid     <= 1'b1;
		request_ch.target_hz <= target;
		do @(posedge clk); while (!request_ch.ready);
		pending_settings.push_back(best_setting(target));
	endtask

	// Extremes of the target, zero (all candidates tried, ties to the first
	// found), exact prescaled clocks and the top end where the winning
	// frequency overflows 16 bits
	task automatic test_extreme_targets();
		send_target('0);
		send_target('1);
		send_target(16'hFFFE);
		send_target(16'd65000);
		send_target(16'd12288);
		send_target(16'd12289);
		send_target(16'd38400);
		send_target(16'd2);
		send_target(16'd50);
	endtask

	// Each bit of the target on its own
	task automatic test_single_bit_targets();
		for (int b = 0; b < TARGET_W; b++)
			send_target(TARGET_W'(1) << b);
	endtask

	// Mostly full-range targets; a few small ones, which cost a long search
	task automatic test_random_targets(input int unsigned items, input int unsigned tx_pct,
		input int unsigned rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (items) begin
			if ($urandom_range(19) == 0)
				send_target(TARGET_W'($urandom_range(255)));
			else
				send_target(TARGET_W'($urandom()));
		end
	endtask

	// Receiver holds off for a long stretch while requests keep coming, so
	// the output register fills and the request side stalls
	task automatic test_output_stall();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		holds_asked <= holds_asked + 1;
		repeat (6)
			send_target(TARGET_W'($urandom_range(65535, 16384)));
	endtask

	// Result side: ready with random idling, or held low for a hold-off
	initial begin
		int unsigned holds_done;
		int unsigned hold_left;
		holds_done      = 0;
		hold_left       = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_asked != holds_done) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Result checking against the oldest prediction
	always @(posedge clk) begin
		timer_setting_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_settings.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result transaction, expected none, actual %0d/%0d/%0d",
					$time, result_ch.achieved_hz, result_ch.prescale_select,
					result_ch.count_value);
			end else begin
				want = pending_settings.pop_front();
				if (result_ch.achieved_hz !== want.freq) begin
					mismatches++;
					$display("%0t: achieved_hz mismatch, expected %0d, actual %0d",
						$time, want.freq, result_ch.achieved_hz);
				end
				if (result_ch.prescale_select !== want.sel) begin
					mismatches++;
					$display("%0t: prescale_select mismatch, expected %0d, actual %0d",
						$time, want.sel, result_ch.prescale_select);
				end
				if (result_ch.count_value !== want.cnt) begin
					mismatches++;
					$display("%0t: count_value mismatch, expected %0d, actual %0d",
						$time, want.cnt, result_ch.count_value);
				end
			end
		end
	end

	// Watchdog: reports mismatches and stops the run if it does not finish
	initial begin
		#200_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		arst_n               = 1'b0;
		request_ch.valid     = 1'b0;
		request_ch.target_hz = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part with the first idle setting
		tx_idle_pct = 16;
		rx_idle_pct = 78;
		test_extreme_targets();
		test_single_bit_targets();

		test_random_targets(RANDOM_ITEMS / 3, 16, 78);
		test_random_targets(RANDOM_ITEMS / 3, 78, 16);
		test_output_stall();
		test_random_targets(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0, 0);

		request_ch.valid <= 1'b0;
		while (pending_settings.size() != 0) @(posedge clk);
		// a stray extra result would show up in this window
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

/* timer_divider_search.f */
sv/tds_pkg.sv
sv/tds_req_if.sv
sv/tds_res_if.sv
sv/tds_divider.sv
sv/tds_seq.sv
sv/timer_divider_search.sv
tb/tb.sv
